@@ hw/rtl/assert_macros.svh @@
// Assertion helpers used by the top-level receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication-style property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ hw/rtl/twslr_pkg.sv @@
`default_nettype none

package twslr_pkg;

    localparam int ShiftBits = 64;
    localparam int CountW    = $clog2(ShiftBits + 1);
    localparam int GroupW    = CountW - 2;
    localparam int JobDepth  = 2;
    localparam int JobPtrW   = $clog2(JobDepth);
    localparam int JobCntW   = $clog2(JobDepth + 1);

    localparam logic [2:0] LatchPort = 3'd3;
    localparam int DataBit  = 1;
    localparam int LatchBit = 2;
    localparam int ClockBit = 3;

    typedef struct packed {
        logic [ShiftBits-1:0] word;
        logic [GroupW-1:0]    groups;
    } t_job;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } t_back_state;

    function automatic logic [3:0] rev_nibble(input logic [3:0] v);
        rev_nibble = {v[0], v[1], v[2], v[3]};
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/twslr_front.sv @@
`default_nettype none

module twslr_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_fire,
    input  wire logic [2:0]          i_port_number,
    input  wire logic [7:0]          i_port_byte,
    output logic                     o_job_push,
    output twslr_pkg::t_job          o_job
);

    logic [twslr_pkg::ShiftBits-1:0] r_word;
    logic [twslr_pkg::ShiftBits-1:0] n_word;
    logic [twslr_pkg::CountW-1:0]    r_count;
    logic [twslr_pkg::CountW-1:0]    n_count;
    logic                            r_prev_clock;
    logic                            n_prev_clock;
    logic                            r_prev_latch;
    logic                            n_prev_latch;

    logic                            w_data;
    logic                            w_latch;
    logic                            w_clock;
    logic                            w_act;
    logic                            w_clock_rise;
    logic                            w_latch_fall;
    logic [twslr_pkg::ShiftBits-1:0] w_word_sh;
    logic [twslr_pkg::CountW-1:0]    w_count_sh;

    always_comb begin
        w_data       = i_port_byte[twslr_pkg::DataBit];
        w_latch      = i_port_byte[twslr_pkg::LatchBit];
        w_clock      = i_port_byte[twslr_pkg::ClockBit];
        w_act        = i_fire && (i_port_number == twslr_pkg::LatchPort);
        w_clock_rise = !r_prev_clock && w_clock;
        w_latch_fall = r_prev_latch && !w_latch;

        // The clock edge is applied first, so a bit shifted by this write is latched too.
        w_word_sh  = w_clock_rise ? {r_word[twslr_pkg::ShiftBits-2:0], w_data} : r_word;
        w_count_sh = r_count;
        if (w_clock_rise && (r_count != twslr_pkg::CountW'(twslr_pkg::ShiftBits))) begin
            w_count_sh = r_count + twslr_pkg::CountW'(1);
        end

        n_word       = r_word;
        n_count      = r_count;
        n_prev_clock = r_prev_clock;
        n_prev_latch = r_prev_latch;
        o_job_push   = 1'b0;
        o_job.word   = w_word_sh;
        o_job.groups = w_count_sh[twslr_pkg::CountW-1:2];

        if (w_act) begin
            n_prev_clock = w_clock;
            n_prev_latch = w_latch;
            if (w_latch_fall) begin
                o_job_push = 1'b1;
                n_word     = '0;
                n_count    = '0;
            end else begin
                n_word  = w_word_sh;
                n_count = w_count_sh;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word       <= '0;
            r_count      <= '0;
            r_prev_clock <= 1'b1;
            r_prev_latch <= 1'b1;
        end else begin
            r_word       <= n_word;
            r_count      <= n_count;
            r_prev_clock <= n_prev_clock;
            r_prev_latch <= n_prev_latch;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/twslr_jobq.sv @@
`default_nettype none

module twslr_jobq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire twslr_pkg::t_job i_job,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output twslr_pkg::t_job      o_job
);

    twslr_pkg::t_job                r_slot [twslr_pkg::JobDepth];
    logic [twslr_pkg::JobPtrW-1:0]  r_wptr;
    logic [twslr_pkg::JobPtrW-1:0]  r_rptr;
    logic [twslr_pkg::JobCntW-1:0]  r_count;
    logic                           w_do_push;
    logic                           w_do_pop;

    always_comb begin
        o_full    = (r_count == twslr_pkg::JobCntW'(twslr_pkg::JobDepth));
        o_empty   = (r_count == '0);
        o_job     = r_slot[r_rptr];
        w_do_push = i_push && !o_full;
        w_do_pop  = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slot[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) begin
                r_wptr <= r_wptr + twslr_pkg::JobPtrW'(1);
            end
            if (w_do_pop) begin
                r_rptr <= r_rptr + twslr_pkg::JobPtrW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + twslr_pkg::JobCntW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - twslr_pkg::JobCntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/twslr_back.sv @@
`default_nettype none

module twslr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_job_empty,
    input  wire twslr_pkg::t_job i_job,
    output logic                 o_job_pop,
    input  wire logic            pop,
    output logic                 empty,
    output logic                 o_is_address,
    output logic [3:0]           o_nibble,
    output logic [3:0]           o_nibble_index,
    output logic                 o_last
);

    twslr_pkg::t_back_state          r_state;
    twslr_pkg::t_back_state          n_state;
    logic [twslr_pkg::ShiftBits-1:0] r_word;
    logic [twslr_pkg::ShiftBits-1:0] n_word;
    logic [twslr_pkg::GroupW-1:0]    r_groups;
    logic [twslr_pkg::GroupW-1:0]    n_groups;
    logic [3:0]                      r_k;
    logic [3:0]                      n_k;

    logic                            r_out_valid;
    logic                            n_out_valid;
    logic                            r_is_address;
    logic                            n_is_address;
    logic [3:0]                      r_nibble;
    logic [3:0]                      n_nibble;
    logic [3:0]                      r_index;
    logic [3:0]                      n_index;
    logic                            r_last;
    logic                            n_last;

    logic                            w_slot_free;
    logic [4:0]                      w_k_next;
    logic                            w_is_last;

    always_comb begin
        w_slot_free = !r_out_valid || pop;
        w_k_next    = {1'b0, r_k} + 5'd1;
        // The address result alone closes the event when fewer than two groups were counted.
        if (r_k == 4'd0) begin
            w_is_last = (r_groups < twslr_pkg::GroupW'(2));
        end else begin
            w_is_last = (w_k_next == 5'(r_groups));
        end

        n_state      = r_state;
        n_word       = r_word;
        n_groups     = r_groups;
        n_k          = r_k;
        n_out_valid  = r_out_valid && !pop;
        n_is_address = r_is_address;
        n_nibble     = r_nibble;
        n_index      = r_index;
        n_last       = r_last;
        o_job_pop    = 1'b0;

        case (r_state)
            twslr_pkg::BACK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_word    = i_job.word;
                    n_groups  = i_job.groups;
                    n_k       = 4'd0;
                    n_state   = twslr_pkg::BACK_EMIT;
                end
            end
            twslr_pkg::BACK_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid  = 1'b1;
                    n_is_address = (r_k == 4'd0);
                    n_nibble     = twslr_pkg::rev_nibble(r_word[3:0]);
                    n_index      = (r_k == 4'd0) ? 4'd0 : r_k - 4'd1;
                    n_last       = w_is_last;
                    n_word       = r_word >> 4;
                    n_k          = w_k_next[3:0];
                    if (w_is_last) begin
                        n_state = twslr_pkg::BACK_IDLE;
                    end
                end
            end
            default: begin
                n_state = twslr_pkg::BACK_IDLE;
            end
        endcase

        empty          = !r_out_valid;
        o_is_address   = r_is_address;
        o_nibble       = r_nibble;
        o_nibble_index = r_index;
        o_last         = r_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twslr_pkg::BACK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word       <= n_word;
        r_groups     <= n_groups;
        r_k          <= n_k;
        r_is_address <= n_is_address;
        r_nibble     <= n_nibble;
        r_index      <= n_index;
        r_last       <= n_last;
    end

endmodule

`default_nettype wire

@@ hw/rtl/three_wire_serial_latch_receiver.sv @@
// Port writes are accepted every cycle while the two-entry transaction queue between the
// front and back parts has room.
// A latch event's write pushes it into the queue; the back part then loads it and registers
// its results onto the result ports, one result per cycle (up to sixteen) while results are
// popped as they appear, and loads the next event only after the current one's last result.
// Reset is synchronous and active low: it empties both queues, clears the shift register and
// bit counter, and sets the remembered clock and latch lines high.
`default_nettype none

`include "assert_macros.svh"

module three_wire_serial_latch_receiver (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [2:0] i_port_number,
    input  wire logic [7:0] i_port_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic            o_is_address,
    output logic [3:0]      o_nibble,
    output logic [3:0]      o_nibble_index,
    output logic            o_last
);

    logic            w_fire;
    logic            w_q_push;
    logic            w_q_full;
    logic            w_q_empty;
    logic            w_q_pop;
    twslr_pkg::t_job w_job_in;
    twslr_pkg::t_job w_job_out;

    assign full   = w_q_full;
    assign w_fire = push && !w_q_full;

    twslr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_port_number (i_port_number),
        .i_port_byte   (i_port_byte),
        .o_job_push    (w_q_push),
        .o_job         (w_job_in)
    );

    twslr_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_job_in),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_job   (w_job_out)
    );

    twslr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_empty    (w_q_empty),
        .i_job          (w_job_out),
        .o_job_pop      (w_q_pop),
        .pop            (pop),
        .empty          (empty),
        .o_is_address   (o_is_address),
        .o_nibble       (o_nibble),
        .o_nibble_index (o_nibble_index),
        .o_last         (o_last)
    );

    `ASSERT_NEVER(a_q_full_and_empty, i_clk, i_rst_n, w_q_full && w_q_empty, "job queue full and empty")
    `ASSERT_CLK(a_push_has_room, i_clk, i_rst_n, w_q_push |-> !w_q_full, "job pushed into full queue")
    `ASSERT_CLK(a_pop_has_job, i_clk, i_rst_n, w_q_pop |-> !w_q_empty, "job popped from empty queue")
    `ASSERT_CLK(a_addr_index_zero, i_clk, i_rst_n, (!empty && o_is_address) |-> (o_nibble_index == 4'd0), "address result with nonzero index")

endmodule

`default_nettype wire
